@@ hw/rtl/fppd_pkg.sv @@
// Shared types and constants for the frequency-pruned pair dictionary.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package fppd_pkg;

  localparam int DICT_SIZE = 1024;
  localparam int IDX_W     = 10;
  localparam int PTR_W     = 11;
  localparam int SYM_W     = 32;
  localparam int CODE_W    = 32;
  localparam int FREQ_W    = 32;
  localparam int CNT_W     = 11;
  localparam int HASH_ADD  = 3;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(DICT_SIZE);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_LK_HEAD, ST_LK_HEADW, ST_LK_READ, ST_LK_CMP,
    ST_ADD_POP, ST_ADD_LINK, ST_MIN, ST_FIX_INIT, ST_FIX, ST_BK_INIT,
    ST_BK_HEAD, ST_BK_HEADW, ST_BK_NODE, ST_BK_EVAL, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_CAPTURE, CMD_HASH, CMD_LK_HEAD, CMD_LK_HEADW,
    CMD_LK_READ, CMD_LK_CMP, CMD_ADD_POP, CMD_ADD_LINK, CMD_MIN, CMD_FIX_INIT,
    CMD_FIX, CMD_BK_INIT, CMD_BK_HEAD, CMD_BK_HEADW, CMD_BK_NODE, CMD_BK_EVAL,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic scan_done;
    logic chain_end;
    logic match;
    logic is_add;
    logic free_empty;
    logic will_fill;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/fppd_ctrl.sv @@
// Controller state machine of the pair dictionary.
// Depends on fppd_pkg; drives commands to fppd_dp and reads its status.
`default_nettype none
module fppd_ctrl
  import fppd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t status,
  output logic         in_ready,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (status.idx_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_CAPTURE;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd        = CMD_HASH;
        state_next = status.is_add ? ST_ADD_POP : ST_LK_HEAD;
      end
      ST_LK_HEAD: begin
        cmd        = CMD_LK_HEAD;
        state_next = ST_LK_HEADW;
      end
      ST_LK_HEADW: begin
        cmd        = CMD_LK_HEADW;
        state_next = ST_LK_READ;
      end
      ST_LK_READ: begin
        cmd        = CMD_LK_READ;
        state_next = status.chain_end ? ST_DONE : ST_LK_CMP;
      end
      ST_LK_CMP: begin
        cmd        = CMD_LK_CMP;
        state_next = status.match ? ST_DONE : ST_LK_READ;
      end
      ST_ADD_POP: begin
        cmd        = CMD_ADD_POP;
        state_next = status.free_empty ? ST_DONE : ST_ADD_LINK;
      end
      ST_ADD_LINK: begin
        cmd        = CMD_ADD_LINK;
        state_next = status.will_fill ? ST_MIN : ST_DONE;
      end
      ST_MIN: begin
        cmd = CMD_MIN;
        if (status.scan_done) state_next = ST_FIX_INIT;
      end
      ST_FIX_INIT: begin
        cmd        = CMD_FIX_INIT;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd = CMD_FIX;
        if (status.scan_done) state_next = ST_BK_INIT;
      end
      ST_BK_INIT: begin
        cmd        = CMD_BK_INIT;
        state_next = ST_BK_HEAD;
      end
      ST_BK_HEAD: begin
        cmd        = CMD_BK_HEAD;
        state_next = status.idx_end ? ST_DONE : ST_BK_HEADW;
      end
      ST_BK_HEADW: begin
        cmd        = CMD_BK_HEADW;
        state_next = ST_BK_NODE;
      end
      ST_BK_NODE: begin
        cmd        = CMD_BK_NODE;
        state_next = status.chain_end ? ST_BK_HEAD : ST_BK_EVAL;
      end
      ST_BK_EVAL: begin
        cmd        = CMD_BK_EVAL;
        state_next = ST_BK_NODE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd        = CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/fppd_dp.sv @@
// Datapath of the pair dictionary: slot memories, bucket heads, free stack,
// counters and the output register. Depends on fppd_pkg; driven by fppd_ctrl.
`default_nettype none
module fppd_dp
  import fppd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic              in_op,
  input  wire logic [SYM_W-1:0]  in_left,
  input  wire logic [SYM_W-1:0]  in_right,
  input  wire logic [CODE_W-1:0] in_code,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   out_hit,
  output logic [CODE_W-1:0]      out_code,
  output logic                   out_swept,
  output logic [CNT_W-1:0]       out_freed
);

  logic [CODE_W-1:0] mem_code  [DICT_SIZE];
  logic [SYM_W-1:0]  mem_left  [DICT_SIZE];
  logic [SYM_W-1:0]  mem_right [DICT_SIZE];
  logic [FREQ_W-1:0] mem_freq  [DICT_SIZE];
  logic [PTR_W-1:0]  mem_next  [DICT_SIZE];
  logic [PTR_W-1:0]  mem_head  [DICT_SIZE];
  logic [IDX_W-1:0]  mem_stack [DICT_SIZE];

  logic [CODE_W-1:0] code_rd;
  logic [SYM_W-1:0]  left_rd, right_rd;
  logic [FREQ_W-1:0] freq_rd;
  logic [PTR_W-1:0]  next_rd, head_rd;
  logic [IDX_W-1:0]  stack_rd;

  logic              op;
  logic [SYM_W-1:0]  left_sym, right_sym;
  logic [CODE_W-1:0] new_code;
  logic [IDX_W-1:0]  bucket, pidx;
  logic [PTR_W-1:0]  p, prev, idx;
  logic              pend, stack_init;
  logic [FREQ_W-1:0] minf;
  logic [CNT_W-1:0]  freed, free_count, used_count;
  logic              res_hit, res_swept;
  logic [CODE_W-1:0] res_code;
  logic [CNT_W-1:0]  res_freed;

  logic [IDX_W-1:0]  node_ra, head_ra, stack_ra;
  logic              head_we, next_we, freq_we, slot_we, stack_we;
  logic [IDX_W-1:0]  head_wa, next_wa, freq_wa, stack_wa, slot;
  logic [PTR_W-1:0]  head_wd, next_wd;
  logic [FREQ_W-1:0] freq_wd, meff;
  logic [IDX_W-1:0]  stack_wd, lp3;
  logic [2*IDX_W-1:0] prod;
  logic              fix_dead;
  logic [PTR_W-1:0]  fresh_slot;

  // Bucket = ((left + 3) * right) mod 1024, so only the low bits matter.
  assign lp3  = left_sym[IDX_W-1:0] + IDX_W'(HASH_ADD);
  assign prod = lp3 * right_sym[IDX_W-1:0];

  assign meff       = (minf == '0) ? FREQ_W'(1) : minf;
  assign fix_dead   = (freq_rd <= meff);
  assign fresh_slot = NIL - free_count;
  assign slot       = stack_init ? stack_rd : fresh_slot[IDX_W-1:0];

  always_comb begin
    node_ra  = p[IDX_W-1:0];
    head_ra  = bucket;
    stack_ra = IDX_W'(free_count - CNT_W'(1));
    head_we  = 1'b0;
    head_wa  = bucket;
    head_wd  = NIL;
    next_we  = 1'b0;
    next_wa  = slot;
    next_wd  = head_rd;
    freq_we  = 1'b0;
    freq_wa  = p[IDX_W-1:0];
    freq_wd  = '0;
    slot_we  = 1'b0;
    stack_we = 1'b0;
    stack_wa = freed[IDX_W-1:0];
    stack_wd = pidx;
    case (cmd)
      CMD_CLEAR: begin
        head_we = !idx[IDX_W];
        head_wa = idx[IDX_W-1:0];
      end
      CMD_LK_CMP: begin
        if (status.match) begin
          freq_we = 1'b1;
          freq_wd = (freq_rd == '1) ? freq_rd : freq_rd + FREQ_W'(1);
        end
      end
      CMD_ADD_LINK: begin
        next_we = 1'b1;
        head_we = 1'b1;
        head_wd = {1'b0, slot};
        slot_we = 1'b1;
        freq_we = 1'b1;
        freq_wa = slot;
        freq_wd = FREQ_W'(1);
      end
      CMD_MIN: node_ra = idx[IDX_W-1:0];
      CMD_FIX: begin
        node_ra = idx[IDX_W-1:0];
        freq_wa = pidx;
        if (pend) begin
          freq_we  = 1'b1;
          freq_wd  = fix_dead ? '0 : freq_rd - meff;
          stack_we = fix_dead;
        end
      end
      CMD_BK_HEAD: head_ra = idx[IDX_W-1:0];
      CMD_BK_EVAL: begin
        // Freed slots carry frequency zero; splice them out of the chain.
        if (freq_rd == '0) begin
          if (prev[IDX_W]) begin
            head_we = 1'b1;
            head_wa = idx[IDX_W-1:0];
            head_wd = next_rd;
          end else begin
            next_we = 1'b1;
            next_wa = prev[IDX_W-1:0];
            next_wd = next_rd;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      mem_code[slot]  <= new_code;
      mem_left[slot]  <= left_sym;
      mem_right[slot] <= right_sym;
    end
    code_rd  <= mem_code[node_ra];
    left_rd  <= mem_left[node_ra];
    right_rd <= mem_right[node_ra];
  end

  always_ff @(posedge clk) begin
    if (freq_we) mem_freq[freq_wa] <= freq_wd;
    freq_rd <= mem_freq[node_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) mem_next[next_wa] <= next_wd;
    next_rd <= mem_next[node_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) mem_head[head_wa] <= head_wd;
    head_rd <= mem_head[head_ra];
  end

  always_ff @(posedge clk) begin
    if (stack_we) mem_stack[stack_wa] <= stack_wd;
    stack_rd <= mem_stack[stack_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend       <= 1'b0;
      free_count <= CNT_W'(DICT_SIZE);
      used_count <= '0;
      stack_init <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd != CMD_OUT) out_valid <= 1'b0;
      case (cmd)
        CMD_CLEAR: if (!idx[IDX_W]) idx <= idx + PTR_W'(1);
        CMD_CAPTURE: begin
          op        <= in_op;
          left_sym  <= in_left;
          right_sym <= in_right;
          new_code  <= in_code;
        end
        CMD_HASH: begin
          bucket    <= prod[IDX_W-1:0];
          res_hit   <= 1'b0;
          res_code  <= '1;
          res_swept <= 1'b0;
          res_freed <= '0;
        end
        CMD_LK_HEADW: p <= head_rd;
        CMD_LK_CMP: begin
          if (status.match) begin
            res_hit  <= 1'b1;
            res_code <= code_rd;
          end else begin
            p <= next_rd;
          end
        end
        CMD_ADD_LINK: begin
          free_count <= free_count - CNT_W'(1);
          used_count <= used_count + CNT_W'(1);
          idx        <= '0;
          pend       <= 1'b0;
          minf       <= '1;
          freed      <= '0;
        end
        CMD_MIN: begin
          if (pend && freq_rd < minf) minf <= freq_rd;
          pend <= !idx[IDX_W];
          if (!idx[IDX_W]) idx <= idx + PTR_W'(1);
        end
        CMD_FIX_INIT: begin
          idx  <= '0;
          pend <= 1'b0;
        end
        CMD_FIX: begin
          pidx <= idx[IDX_W-1:0];
          pend <= !idx[IDX_W];
          if (!idx[IDX_W]) idx <= idx + PTR_W'(1);
          if (pend && fix_dead) freed <= freed + CNT_W'(1);
        end
        CMD_BK_INIT: begin
          idx        <= '0;
          free_count <= freed;
          used_count <= used_count - freed;
          stack_init <= 1'b1;
        end
        CMD_BK_HEAD: begin
          if (idx[IDX_W]) begin
            res_swept <= 1'b1;
            res_freed <= freed;
          end
        end
        CMD_BK_HEADW: begin
          p    <= head_rd;
          prev <= NIL;
        end
        CMD_BK_NODE: if (p[IDX_W]) idx <= idx + PTR_W'(1);
        CMD_BK_EVAL: begin
          if (freq_rd != '0) prev <= p;
          p <= next_rd;
        end
        CMD_OUT: begin
          out_valid <= 1'b1;
          out_hit   <= res_hit;
          out_code  <= res_code;
          out_swept <= res_swept;
          out_freed <= res_freed;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.idx_end    = idx[IDX_W];
    status.scan_done  = idx[IDX_W] && !pend;
    status.chain_end  = p[IDX_W];
    status.match      = (left_rd == left_sym) && (right_rd == right_sym);
    status.is_add     = op;
    status.free_empty = (free_count == '0);
    status.will_fill  = (used_count >= CNT_W'(DICT_SIZE - 1));
    status.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ hw/rtl/frequency_pruned_pair_dictionary.sv @@
// Channel   Dir  Signals                      Contents
// s (input) in   s_tvalid s_tready s_tdata    left_symbol, right_symbol, new_code
//                s_tuser                      op
// m (result)out  m_tvalid m_tready m_tdata    rule_code, freed_count
//                m_tuser                      hit, swept
// One item at a time. A lookup hashes the pair, reads the bucket head and then reads
// and compares one chain node at a time until a hit or the chain end; an add without
// pruning links a free slot at the head of its chain. Each memory has one read port.
// An add that fills the table runs a sweep over the frequencies, which finds the least
// one, then lowers each one or frees its slot, followed by a pass over the bucket chains.
// After reset a pass empties all 1024 bucket heads; s_tready stays low meanwhile.
// A result waits in the output register while the next transfer is accepted.
// Depends on fppd_pkg, fppd_ctrl and fppd_dp.
`default_nettype none
module frequency_pruned_pair_dictionary
  import fppd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,   // left_symbol, right_symbol, new_code
  input  wire logic [0:0]   s_tuser,   // op
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [47:0]       m_tdata,   // rule_code, freed_count, zero pad
  output logic [1:0]        m_tuser    // hit, swept
);

  cmd_t              cmd;
  status_t           status;
  logic              hit, swept;
  logic [CODE_W-1:0] rule_code;
  logic [CNT_W-1:0]  freed_count;

  fppd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  fppd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_op     (s_tuser[0]),
    .in_left   (s_tdata[31:0]),
    .in_right  (s_tdata[63:32]),
    .in_code   (s_tdata[95:64]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_hit   (hit),
    .out_code  (rule_code),
    .out_swept (swept),
    .out_freed (freed_count)
  );

  assign m_tdata = {5'd0, freed_count, rule_code};
  assign m_tuser = {swept, hit};

endmodule
`default_nettype wire

@@ hw/rtl/fppd_check.sv @@
// Port-level checker for the pair dictionary, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module fppd_check (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [47:0]  m_tdata,
  input wire logic [1:0]   m_tuser
);

  // The bucket heads are being emptied right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during the clearing pass");

  // One item in flight: an accepted transfer closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer accepted while an item is at work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped or changed while stalled");

  a_hit_no_sweep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result marks both a hit and a sweep");

  a_freed_only_swept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[42:32] == 11'd0)
    else $error("freed count without a sweep");

endmodule

bind frequency_pruned_pair_dictionary fppd_check u_fppd_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/tb_frequency_pruned_pair_dictionary.sv @@
// Self-checking testbench for the frequency-pruned pair dictionary.
// A built-in dictionary predictor checks every result; depends on fppd_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_frequency_pruned_pair_dictionary;
  import fppd_pkg::*;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;
  localparam logic [CODE_W-1:0] DUMMY_CODE = '1;

  typedef struct {
    logic              op;
    logic [SYM_W-1:0]  left;
    logic [SYM_W-1:0]  right;
    logic [CODE_W-1:0] code;
    bit                drain;  // wait for all results before this item
    bit                quiet;  // no gap after this item
  } pair_req_t;

  typedef struct {
    logic              hit;
    logic [CODE_W-1:0] code;
    logic              swept;
    logic [CNT_W-1:0]  freed;
  } dict_result_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;

  frequency_pruned_pair_dictionary DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predicted dictionary contents.
  logic [CODE_W-1:0] rule_code_mem [DICT_SIZE];
  logic [SYM_W-1:0]  rule_left_mem [DICT_SIZE];
  logic [SYM_W-1:0]  rule_right_mem[DICT_SIZE];
  logic [FREQ_W-1:0] rule_freq_mem [DICT_SIZE];
  int unsigned       chain_head    [DICT_SIZE];
  int unsigned       chain_next    [DICT_SIZE];
  int unsigned       free_slots    [DICT_SIZE];
  int unsigned       n_free, n_used;

  pair_req_t    pending_q[$];
  dict_result_t expected_q[$];
  pair_req_t    pair_pool[$];
  int errors = 0;
  int n_lookups = 0, n_hits = 0, n_adds = 0, n_sweeps = 0, n_freed = 0;
  int results_seen = 0;

  function automatic int unsigned bucket_of_pair(logic [SYM_W-1:0] l, logic [SYM_W-1:0] r);
    logic [63:0] prod;
    prod = (64'(l) + 64'(HASH_ADD)) * 64'(r);
    return prod % DICT_SIZE;
  endfunction

  function automatic void unlink_rule(int unsigned slot);
    int unsigned b, p, prev;
    b = bucket_of_pair(rule_left_mem[slot], rule_right_mem[slot]);
    p = chain_head[b];
    prev = DICT_SIZE;
    while (p < DICT_SIZE) begin
      if (p == slot) begin
        if (prev == DICT_SIZE) chain_head[b] = chain_next[p];
        else chain_next[prev] = chain_next[p];
        break;
      end
      prev = p;
      p = chain_next[p];
    end
    chain_next[slot] = DICT_SIZE;
    rule_code_mem[slot] = DUMMY_CODE;
    rule_left_mem[slot] = DUMMY_CODE;
    rule_right_mem[slot] = DUMMY_CODE;
  endfunction

  // Lowers all frequencies by the smallest one and frees the rules that reach zero.
  function automatic int unsigned prune_rules();
    logic [FREQ_W-1:0] lowest;
    int unsigned freed;
    lowest = '1;
    freed = 0;
    for (int i = 0; i < DICT_SIZE; i++)
      if (rule_freq_mem[i] < lowest) lowest = rule_freq_mem[i];
    if (lowest == 0) lowest = 1;
    for (int i = 0; i < DICT_SIZE; i++) begin
      if (rule_freq_mem[i] <= lowest) begin
        rule_freq_mem[i] = 0;
        unlink_rule(i);
        if (n_free < DICT_SIZE) begin
          free_slots[n_free] = i;
          n_free++;
        end
        if (n_used > 0) n_used--;
        freed++;
      end else begin
        rule_freq_mem[i] -= lowest;
      end
    end
    return freed;
  endfunction

  function automatic dict_result_t apply_pair_op(logic op, logic [SYM_W-1:0] l,
                                                 logic [SYM_W-1:0] r, logic [CODE_W-1:0] c);
    dict_result_t res;
    int unsigned b, p, slot;
    res.hit = 1'b0;
    res.code = DUMMY_CODE;
    res.swept = 1'b0;
    res.freed = '0;
    b = bucket_of_pair(l, r);
    if (op == OP_LOOKUP) begin
      n_lookups++;
      p = chain_head[b];
      while (p < DICT_SIZE) begin
        if (rule_left_mem[p] == l && rule_right_mem[p] == r) begin
          if (rule_freq_mem[p] != '1) rule_freq_mem[p]++;
          res.hit = 1'b1;
          res.code = rule_code_mem[p];
          n_hits++;
          break;
        end
        p = chain_next[p];
      end
    end else if (n_free != 0) begin
      n_adds++;
      n_free--;
      slot = free_slots[n_free];
      chain_next[slot] = chain_head[b];
      chain_head[b] = slot;
      rule_code_mem[slot] = c;
      rule_left_mem[slot] = l;
      rule_right_mem[slot] = r;
      rule_freq_mem[slot] = 1;
      n_used++;
      if (n_used >= DICT_SIZE) begin
        res.swept = 1'b1;
        res.freed = CNT_W'(prune_rules());
        n_sweeps++;
        n_freed += res.freed;
      end
    end
    return res;
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Result checking and prediction of every accepted transfer.
  always @(posedge clk) begin
    dict_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h/%h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = expected_q.pop_front();
          report_field("hit", want.hit, m_tuser[0]);
          report_field("swept", want.swept, m_tuser[1]);
          report_field("rule_code", want.code, m_tdata[31:0]);
          report_field("freed_count", want.freed, m_tdata[42:32]);
          report_field("pad", 0, m_tdata[47:43]);
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(apply_pair_op(s_tuser[0], s_tdata[31:0], s_tdata[63:32],
                                           s_tdata[95:64]));
    end
  end

  // Sender.
  int send_gap = 0;
  always @(posedge clk) begin
    pair_req_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_q[0].drain && (s_tvalid || expected_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        item = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {item.code, item.right, item.left};
        s_tuser <= item.op;
        if (item.quiet) send_gap <= 0;
        else if ($urandom_range(0, 99) < 65) send_gap <= 0;
        else if ($urandom_range(0, 99) < 90) send_gap <= $urandom_range(1, 3);
        else send_gap <= $urandom_range(15, 60);
      end
    end
  end

  // Receiver, with one long hold-off that backs the block up.
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done <= 1'b1;
      hold_left <= 500;
      m_tready <= 1'b0;
    end else if (results_seen >= 600 && results_seen < 800) begin
      m_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      m_tready <= (pick < 80);
      if (pick >= 80 && pick < 95) hold_left <= $urandom_range(0, 2);
      else if (pick >= 95) hold_left <= $urandom_range(20, 80);
    end
  end

  function automatic logic [SYM_W-1:0] rand_symbol();
    logic [SYM_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 15);
    if (v == '1) v = v - 1;
    return v;
  endfunction

  task automatic queue_item(logic op, logic [SYM_W-1:0] l, logic [SYM_W-1:0] r,
                            logic [CODE_W-1:0] c, bit drain, bit quiet);
    pair_req_t it;
    it.op = op; it.left = l; it.right = r; it.code = c; it.drain = drain; it.quiet = quiet;
    pending_q.push_back(it);
  endtask

  initial begin
    pair_req_t p;
    int n_items, adds_planned, pick;
    bit quiet_run;
    for (int i = 0; i < DICT_SIZE; i++) begin
      rule_code_mem[i] = DUMMY_CODE;
      rule_left_mem[i] = DUMMY_CODE;
      rule_right_mem[i] = DUMMY_CODE;
      rule_freq_mem[i] = '0;
      chain_head[i] = DICT_SIZE;
      chain_next[i] = DICT_SIZE;
      free_slots[i] = DICT_SIZE - 1 - i;
    end
    n_free = DICT_SIZE;
    n_used = 0;

    // Directed: empty table, extremes, duplicate adds that shadow older rules.
    queue_item(OP_LOOKUP, 0, 0, 0, 0, 0);
    queue_item(OP_ADD, 0, 0, 0, 0, 0);
    queue_item(OP_LOOKUP, 0, 0, 32'h1234_5678, 0, 0);
    queue_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0, 0);
    queue_item(OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0);
    queue_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0, 0);
    queue_item(OP_ADD, 0, 0, 32'hA5A5_5A5A, 0, 0);
    queue_item(OP_LOOKUP, 0, 0, 0, 0, 0);
    queue_item(OP_ADD, 32'hFFFF_FFFE, 0, 32'h5555_5555, 0, 1);
    queue_item(OP_ADD, 0, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 0, 1);
    queue_item(OP_LOOKUP, 32'hFFFF_FFFE, 0, 0, 0, 1);
    queue_item(OP_LOOKUP, 0, 32'hFFFF_FFFE, 0, 0, 1);
    queue_item(OP_LOOKUP, 1, 0, 0, 0, 0);
    queue_item(OP_ADD, 1021, 1, 32'h0000_0001, 0, 0);  // same bucket as (0,0)
    queue_item(OP_LOOKUP, 1021, 1, 0, 0, 0);
    queue_item(OP_LOOKUP, 0, 0, 0, 1, 0);

    // Random: lone adds and lookups followed by an add of the same pair, plus noise.
    // Enough adds are planned to fill the table and force a sweep.
    n_items = 0;
    adds_planned = 0;
    quiet_run = 0;
    while (n_items < 1500 || adds_planned < 1100) begin
      if (n_items % 100 == 0) quiet_run = ($urandom_range(0, 3) == 0);
      if (pair_pool.size() > 0 && $urandom_range(0, 99) < 35) begin
        p = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
      end else begin
        p.left = rand_symbol();
        p.right = rand_symbol();
        if (pair_pool.size() < 200) pair_pool.push_back(p);
      end
      p.code = $urandom;
      if (p.code == '1) p.code = 0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        queue_item(OP_LOOKUP, p.left, p.right, $urandom, n_items % 400 == 399, quiet_run);
        queue_item(OP_ADD, p.left, p.right, p.code, 0, quiet_run);
        n_items += 2;
        adds_planned++;
      end else if (pick < 97) begin
        queue_item(OP_ADD, p.left, p.right, p.code, 0, quiet_run);
        n_items++;
        adds_planned++;
      end else begin
        queue_item(OP_LOOKUP, p.left, p.right, p.code, 0, quiet_run);
        n_items++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d lookups (%0d hits) and %0d adds, with %0d sweeps freeing %0d rules.",
             n_lookups, n_hits, n_adds, n_sweeps, n_freed);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out with %0d results outstanding.", expected_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
